// ----- rtl/hto_pkg.sv -----
`timescale 1ns / 1ps

package hto_pkg;

  localparam int HTO_BUCKETS = 16;

  localparam int FUNC_W   = 2;
  localparam int KEY_W    = 16;
  localparam int STEP_W   = 4;
  localparam int STATUS_W = 2;
  localparam int BUCKET_W = 4;
  localparam int PROBES_W = 5;

  // Operation codes carried in the func field. The fourth code is a no-op.
  typedef logic [FUNC_W-1:0] func_t;
  localparam func_t FUNC_CLEAR  = 2'd0;
  localparam func_t FUNC_INSERT = 2'd1;
  localparam func_t FUNC_LOOKUP = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FOUND = 2'd1,
    ST_MISS  = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_CLEAR,
    S_HOME,
    S_PROBE,
    S_RESP
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load_item;
    logic    home;
    logic    advance;
    logic    wr_slot;
    logic    sweep;
    logic    set_res;
    status_t res_status;
    logic    res_pos;
    logic    res_cnt;
    logic    load_out;
  } hto_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic slot_valid;
    logic key_match;
    logic wrap;
    logic sweep_last;
    logic out_free;
  } hto_stat_t;

endpackage

// ----- rtl/hto_item_if.sv -----
`timescale 1ns / 1ps

interface hto_item_if import hto_pkg::*;;
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [KEY_W-1:0]  key;

  modport source (output valid, output func, output key, input ready);
  modport sink (input valid, input func, input key, output ready);
endinterface

// ----- rtl/hto_result_if.sv -----
`timescale 1ns / 1ps

interface hto_result_if import hto_pkg::*;;
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [BUCKET_W-1:0] bucket;
  logic [PROBES_W-1:0] probes;

  modport source (output valid, output status, output bucket, output probes, input ready);
  modport sink (input valid, input status, input bucket, input probes, output ready);
endinterface

// ----- rtl/hash_table_open_addressing_core.sv -----
`timescale 1ns / 1ps

// Open-addressing hash table of BUCKETS key slots with a programmable probe step.
// The in_ch channel carries one operation per transaction (clear, insert or
// look up a key); the out_ch channel returns one result transaction for each,
// with status, bucket and probe count, in order. cfg_wr_en/cfg_wr_data set
// the probe step and are meant to be written while the block is idle.
// An insert or lookup examines 1 to BUCKETS buckets, and the next transaction
// is taken only after the previous result is loaded into the output register.
// The probe loop examines one bucket per cycle through the slot memory's read
// port, whose read address runs one bucket ahead. A clear walks the memory
// one slot per cycle. After reset the block runs a clearing pass over all
// BUCKETS slots with in_ch ready low; the probe step returns to 1. If the
// receiver stalls, the finished result waits in the output register and the
// next transaction is still accepted and processed; the block then holds its
// next result until the output register is free.
module hash_table_open_addressing_core import hto_pkg::*; #(
  parameter int BUCKETS = HTO_BUCKETS
) (
  input  logic              clk,
  input  logic              rst_n,
  hto_item_if.sink          in_ch,
  hto_result_if.source      out_ch,
  input  logic              cfg_wr_en,
  input  logic [STEP_W-1:0] cfg_wr_data
);

  hto_cmd_t  cmd;
  hto_stat_t stat;
  logic      in_ready;

  assign in_ch.ready = in_ready;

  // The controller sequences each operation; the datapath owns the table.
  hto_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_func  (in_ch.func),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  hto_datapath #(
    .BUCKETS (BUCKETS)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_key      (in_ch.key),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .cmd         (cmd),
    .stat        (stat),
    .out_ch      (out_ch)
  );

endmodule

// ----- rtl/hto_ctrl.sv -----
`timescale 1ns / 1ps

module hto_ctrl import hto_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  func_t     in_func,
  output logic      in_ready,
  input  hto_stat_t stat,
  output hto_cmd_t  cmd
);

  state_t state_r, state_nxt;
  func_t  func_r, func_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_INIT;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r <= func_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    func_nxt  = func_r;
    in_ready  = 1'b0;
    cmd       = '0;
    case (state_r)
      S_INIT: begin
        cmd.sweep = 1'b1;
        if (stat.sweep_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_item = 1'b1;
          func_nxt      = in_func;
          case (in_func)
            FUNC_CLEAR: begin
              state_nxt = S_CLEAR;
            end
            FUNC_INSERT, FUNC_LOOKUP: begin
              state_nxt = S_HOME;
            end
            default: begin
              cmd.set_res    = 1'b1;
              cmd.res_status = ST_DONE;
              state_nxt      = S_RESP;
            end
          endcase
        end
      end
      S_CLEAR: begin
        cmd.sweep = 1'b1;
        if (stat.sweep_last) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = ST_DONE;
          state_nxt      = S_RESP;
        end
      end
      S_HOME: begin
        cmd.home  = 1'b1;
        state_nxt = S_PROBE;
      end
      S_PROBE: begin
        if (func_r == FUNC_INSERT && !stat.slot_valid) begin
          cmd.wr_slot    = 1'b1;
          cmd.set_res    = 1'b1;
          cmd.res_status = ST_DONE;
          cmd.res_pos    = 1'b1;
          cmd.res_cnt    = 1'b1;
          state_nxt      = S_RESP;
        end else if (func_r != FUNC_INSERT && !stat.slot_valid) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = ST_MISS;
          cmd.res_cnt    = 1'b1;
          state_nxt      = S_RESP;
        end else if (func_r != FUNC_INSERT && stat.key_match) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = ST_FOUND;
          cmd.res_pos    = 1'b1;
          cmd.res_cnt    = 1'b1;
          state_nxt      = S_RESP;
        end else if (stat.wrap) begin
          cmd.set_res    = 1'b1;
          cmd.res_status = (func_r == FUNC_INSERT) ? ST_FULL : ST_MISS;
          cmd.res_cnt    = 1'b1;
          state_nxt      = S_RESP;
        end else begin
          cmd.advance = 1'b1;
        end
      end
      S_RESP: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/hto_datapath.sv -----
`timescale 1ns / 1ps

module hto_datapath import hto_pkg::*; #(
  parameter int BUCKETS = HTO_BUCKETS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [KEY_W-1:0]  in_key,
  input  logic              cfg_wr_en,
  input  logic [STEP_W-1:0] cfg_wr_data,
  input  hto_cmd_t          cmd,
  output hto_stat_t         stat,
  hto_result_if.source      out_ch
);

  localparam int BW    = $clog2(BUCKETS);
  localparam int PW    = $clog2(BUCKETS + 1);
  localparam int SHIFT = KEY_W + BW;
  localparam int MW    = KEY_W + 1;
  localparam int PRW   = KEY_W + MW;
  localparam int CW    = ((BW > STEP_W) ? BW : STEP_W) + 1;
  // Reciprocal of the bucket count, exact for every key of KEY_W bits.
  localparam longint unsigned RECIP = ((64'd1 << SHIFT) + BUCKETS - 1) / BUCKETS;

  logic [KEY_W:0]         mem [BUCKETS];
  logic [KEY_W:0]         rd_data_r;
  logic [BW-1:0]          rd_addr;

  logic [KEY_W-1:0]       key_r;
  logic [KEY_W-1:0]       q_r;
  logic [BW-1:0]          pos_r;
  logic [BW-1:0]          home_r;
  logic [PW-1:0]          cnt_r;
  logic [BW-1:0]          sweep_r;
  logic [BW-1:0]          step_r;

  logic [CW-1:0]          step_rem;
  logic [PRW-1:0]         prod;
  logic [PRW-1:0]         prod_sh;
  logic [KEY_W-1:0]       qb;
  logic [KEY_W-1:0]       key_rem;
  logic [BW-1:0]          home_w;
  logic [BW:0]            sum;
  logic [BW:0]            sum_wrap;
  logic [BW-1:0]          next_pos;
  logic                   sweep_last;

  status_t                res_status_r;
  logic [BUCKET_W-1:0]    res_bucket_r;
  logic [PROBES_W-1:0]    res_probes_r;

  logic                   out_valid_r;
  logic [STATUS_W-1:0]    out_status_r;
  logic [BUCKET_W-1:0]    out_bucket_r;
  logic [PROBES_W-1:0]    out_probes_r;

  // Step reduced modulo the bucket count by repeated subtraction.
  always_comb begin
    step_rem = CW'(cfg_wr_data);
    for (int i = 0; i < 8; i++) begin
      if (step_rem >= CW'(BUCKETS)) begin
        step_rem = step_rem - CW'(BUCKETS);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= BW'(1);
    end else if (cfg_wr_en) begin
      step_r <= step_rem[BW-1:0];
    end
  end

  // Home bucket: quotient by reciprocal multiply, then remainder next cycle.
  assign prod    = PRW'(in_key) * PRW'(RECIP);
  assign prod_sh = prod >> SHIFT;
  assign qb      = KEY_W'(q_r * KEY_W'(BUCKETS));
  assign key_rem = key_r - qb;
  assign home_w  = key_rem[BW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      key_r <= in_key;
      q_r   <= prod_sh[KEY_W-1:0];
    end
  end

  assign sum      = {1'b0, pos_r} + {1'b0, step_r};
  assign sum_wrap = sum - (BW + 1)'(BUCKETS);
  assign next_pos = (sum >= (BW + 1)'(BUCKETS)) ? sum_wrap[BW-1:0] : sum[BW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.home) begin
      pos_r  <= home_w;
      home_r <= home_w;
      cnt_r  <= PW'(1);
    end else if (cmd.advance) begin
      pos_r <= next_pos;
      cnt_r <= cnt_r + PW'(1);
    end
  end

  assign sweep_last = (sweep_r == BW'(BUCKETS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r <= '0;
    end else if (cmd.sweep) begin
      sweep_r <= sweep_last ? '0 : sweep_r + BW'(1);
    end
  end

  // Slot memory: valid bit on top of the key. The read address runs one
  // probe ahead so that each cycle examines one bucket.
  always_comb begin
    if (cmd.home) begin
      rd_addr = home_w;
    end else if (cmd.advance) begin
      rd_addr = next_pos;
    end else begin
      rd_addr = pos_r;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_slot) begin
      mem[pos_r] <= {1'b1, key_r};
    end else if (cmd.sweep) begin
      mem[sweep_r] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.set_res) begin
      res_status_r <= cmd.res_status;
      res_bucket_r <= cmd.res_pos ? BUCKET_W'(pos_r) : '0;
      res_probes_r <= cmd.res_cnt ? PROBES_W'(cnt_r) : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status_r <= res_status_r;
      out_bucket_r <= res_bucket_r;
      out_probes_r <= res_probes_r;
    end
  end

  assign out_ch.valid  = out_valid_r;
  assign out_ch.status = out_status_r;
  assign out_ch.bucket = out_bucket_r;
  assign out_ch.probes = out_probes_r;

  assign stat.slot_valid = rd_data_r[KEY_W];
  assign stat.key_match  = (rd_data_r[KEY_W-1:0] == key_r);
  assign stat.wrap       = (next_pos == home_r) || (cnt_r >= PW'(BUCKETS));
  assign stat.sweep_last = sweep_last;
  assign stat.out_free   = !out_valid_r || out_ch.ready;

endmodule
